// ===== rtl/core/texture_sampler_bilinear_assert.svh =====
// Assertion macros shared by the texture sampler RTL.
`ifndef TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH
`define TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define TSB_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define TSB_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/tsb_pkg.sv =====
// Types, constants and helper functions of the texture sampler.
package tsb_pkg;

  localparam int unsigned TexelCount = 65536;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned MaxDim     = 256;
  localparam int unsigned DimW       = 9;
  localparam int unsigned CoordW     = 24;
  localparam int unsigned WrapW      = 18;
  localparam int unsigned OpW        = 18;
  localparam int unsigned MacW       = 26;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned BlendOps   = 12;

  localparam logic [CfgIdxW-1:0] RegFilter = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWrapU  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWrapV  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd4;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSample = 1'b1;

  localparam logic FilterNearest = 1'b0;
  localparam logic FilterLinear  = 1'b1;

  localparam logic [1:0] WrapRepeat = 2'd0;
  localparam logic [1:0] WrapMirror = 2'd1;

  typedef struct packed {
    logic signed [OpW-1:0]  a;
    logic signed [OpW-1:0]  b;
    logic signed [MacW-1:0] c;
  } mac_op_t;

  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [16:0] t;
  } axis_t;

  // Q8.16 coordinate to wrapped Q.16 value in [-1, 1].
  function automatic logic signed [WrapW-1:0] wrap_coord(
    input logic signed [CoordW-1:0] c,
    input logic [1:0]               mode
  );
    logic [15:0]             m;
    logic [16:0]             r;
    logic signed [WrapW-1:0] f;
    logic signed [WrapW-1:0] res;
    if (!c[CoordW-1] && (c <= 24'sd65536)) begin
      res = c[WrapW-1:0];
    end else begin
      if (c[CoordW-1]) begin
        m = ~c[15:0] + 16'd1;
        f = -$signed({2'b00, m});
        r = (m == 16'd0) ? 17'd0 : 17'h10000 - {1'b0, m};
      end else begin
        m = c[15:0];
        f = $signed({2'b00, m});
        r = {1'b0, m};
      end
      case (mode)
        WrapRepeat: res = $signed({1'b0, r});
        WrapMirror: res = $signed({1'b0, 17'h10000 - r});
        default:    res = f;
      endcase
    end
    return res;
  endfunction

  // Scaled coordinate to neighbour indices (clamped at 0) and blend weight.
  function automatic axis_t axis_split(
    input logic signed [MacW-1:0] x,
    input logic                   nearest
  );
    logic signed [MacW-1:0] xs;
    logic signed [9:0]      fl;
    logic signed [9:0]      cl;
    logic [15:0]            fr;
    axis_t                  a;
    xs   = nearest ? x + 26'sd32768 : x;
    fl   = xs[MacW-1:16];
    fr   = xs[15:0];
    cl   = (nearest || (fr == 16'd0)) ? fl : fl + 10'sd1;
    a.lo = fl[9] ? 8'd0 : fl[7:0];
    a.hi = cl[9] ? 8'd0 : cl[7:0];
    a.t  = (fr == 16'd0) ? 17'h10000 : {1'b0, fr};
    return a;
  endfunction

endpackage

// ===== rtl/core/tsb_if.sv =====
// Valid/ready channel interfaces for sampler requests and results.
interface tsb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [15:0]                         texel_index;
  logic [31:0]                         texel_color;
  logic signed [tsb_pkg::CoordW-1:0]   coord_u;
  logic signed [tsb_pkg::CoordW-1:0]   coord_v;

  modport source (output valid, command, texel_index, texel_color, coord_u, coord_v,
                  input ready);
  modport sink   (input valid, command, texel_index, texel_color, coord_u, coord_v,
                  output ready);
endinterface

interface tsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/core/texture_sampler_bilinear.sv =====
// Top level of the texture sampler: config, sequencer, texel store and result register.
// Texel store of 65536 RGBA words loaded by write items (no result; the sequencer stays
// idle), sampled at signed Q8.16 u,v with per-axis wrap and nearest or bilinear
// filtering. All multiplies run through one shared multiply-add unit under a small
// sequencer; the input is not ready while a sample is in progress. A nearest sample
// steps through two coordinate scalings, one address and one read; a bilinear sample
// runs four address/read/latch rounds on the single texel memory port, then twelve
// channel blends on the same unit. The result sits in an output register, so the next
// item is taken while it waits. Config registers must be written only while idle (the
// block does not enforce it); texels read before being written return unknown data.
`include "texture_sampler_bilinear_assert.svh"

module texture_sampler_bilinear (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsb_pkg::CfgDataW-1:0]   cfg_data_i,
  tsb_in_if.sink                         in_i,
  tsb_out_if.source                      out_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MX, ST_MY, ST_PREP, ST_ADDR, ST_RD, ST_LATCH, ST_BLEND, ST_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] tex_cnt_q;
  logic [3:0] blend_cnt_q;
  logic       out_valid_q;
  logic [31:0] out_data_q;

  logic                         filter_q;
  logic [1:0]                   wrap_u_q;
  logic [1:0]                   wrap_v_q;
  logic [tsb_pkg::DimW-1:0]     width_q;
  logic [tsb_pkg::DimW-1:0]     height_q;

  logic signed [tsb_pkg::WrapW-1:0] wu_q;
  logic signed [tsb_pkg::WrapW-1:0] wv_q;
  logic signed [tsb_pkg::MacW-1:0]  x_q;
  tsb_pkg::axis_t                   ax_q;
  tsb_pkg::axis_t                   ay_q;
  logic [31:0]                      texel_q [4];
  logic [31:0]                      lc_q;
  logic [31:0]                      rc_q;
  logic [31:0]                      res_q;

  logic                            in_acc;
  logic                            ram_we;
  logic [tsb_pkg::AddrW-1:0]       ram_addr;
  logic [31:0]                     ram_rdata;
  logic signed [tsb_pkg::MacW-1:0] p;
  tsb_pkg::mac_op_t                op;

  logic [tsb_pkg::DimW-1:0] w_eff;
  logic [tsb_pkg::DimW-1:0] h_eff;
  logic [7:0]               span_x;
  logic [7:0]               span_y;
  logic [7:0]               col_k;
  logic [7:0]               row_k;

  logic [1:0]        grp;
  logic [1:0]        ch;
  logic [31:0]       word_a;
  logic [31:0]       word_b;
  logic [16:0]       wt;
  logic [7:0]        ca;
  logic [7:0]        cb;
  logic signed [8:0] diff;
  logic [3:0]        cap_idx;
  logic [7:0]        cap_val;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ram_we     = in_acc && (in_i.command == tsb_pkg::CmdWrite);
  assign ram_addr   = (state_q == ST_IDLE) ? in_i.texel_index : p[tsb_pkg::AddrW-1:0];

  assign w_eff  = (width_q > 9'd256) ? 9'd256 : width_q;
  assign h_eff  = (height_q > 9'd256) ? 9'd256 : height_q;
  assign span_x = (w_eff == 9'd0) ? 8'd0 : 8'(w_eff - 9'd1);
  assign span_y = (h_eff == 9'd0) ? 8'd0 : 8'(h_eff - 9'd1);
  assign col_k  = tex_cnt_q[1] ? ax_q.hi : ax_q.lo;
  assign row_k  = tex_cnt_q[0] ? ay_q.hi : ay_q.lo;

  // blend operands: bottom/top of left, bottom/top of right, then left/right
  assign grp = blend_cnt_q[3:2];
  assign ch  = blend_cnt_q[1:0];

  always_comb begin
    case (grp)
      2'd0: begin
        word_a = texel_q[0];
        word_b = texel_q[1];
        wt     = ay_q.t;
      end
      2'd1: begin
        word_a = texel_q[2];
        word_b = texel_q[3];
        wt     = ay_q.t;
      end
      default: begin
        word_a = lc_q;
        word_b = rc_q;
        wt     = ax_q.t;
      end
    endcase
  end

  assign ca      = word_a[{ch, 3'b000} +: 8];
  assign cb      = word_b[{ch, 3'b000} +: 8];
  assign diff    = $signed({1'b0, cb}) - $signed({1'b0, ca});
  assign cap_idx = blend_cnt_q - 4'd1;
  assign cap_val = p[23:16];

  always_comb begin
    op = '0;
    unique case (state_q)
      ST_MX: begin
        op.a = wu_q;
        op.b = $signed({10'd0, span_x});
      end
      ST_MY: begin
        op.a = wv_q;
        op.b = $signed({10'd0, span_y});
      end
      ST_ADDR: begin
        op.a = $signed({10'd0, row_k});
        op.b = $signed({9'd0, w_eff});
        op.c = $signed({18'd0, col_k});
      end
      ST_BLEND: begin
        op.a = {{9{diff[8]}}, diff};
        op.b = $signed({1'b0, wt});
        op.c = $signed({2'b00, ca, 16'd0});
      end
      default: op = '0;
    endcase
  end

  tsb_mac u_mac (
    .clk_i (clk_i),
    .op_i  (op),
    .p_o   (p)
  );

  tsb_ram #(
    .Width (32),
    .Depth (tsb_pkg::TexelCount)
  ) u_texels (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.texel_color),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= tsb_pkg::FilterNearest;
      wrap_u_q <= tsb_pkg::WrapRepeat;
      wrap_v_q <= tsb_pkg::WrapRepeat;
      width_q  <= 9'd1;
      height_q <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsb_pkg::RegFilter: filter_q <= cfg_data_i[0];
        tsb_pkg::RegWrapU:  wrap_u_q <= cfg_data_i[1:0];
        tsb_pkg::RegWrapV:  wrap_v_q <= cfg_data_i[1:0];
        tsb_pkg::RegWidth:  width_q  <= cfg_data_i;
        tsb_pkg::RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tex_cnt_q   <= 2'd0;
      blend_cnt_q <= 4'd0;
      out_valid_q <= 1'b0;
      out_data_q  <= 32'd0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.command == tsb_pkg::CmdSample)) begin
            state_q <= ST_MX;
          end
        end
        ST_MX:   state_q <= ST_MY;
        ST_MY:   state_q <= ST_PREP;
        ST_PREP: begin
          tex_cnt_q <= 2'd0;
          state_q   <= ST_ADDR;
        end
        ST_ADDR: state_q <= ST_RD;
        ST_RD:   state_q <= ST_LATCH;
        ST_LATCH: begin
          if (filter_q == tsb_pkg::FilterNearest) begin
            state_q <= ST_DONE;
          end else if (tex_cnt_q == 2'd3) begin
            blend_cnt_q <= 4'd0;
            state_q     <= ST_BLEND;
          end else begin
            tex_cnt_q <= tex_cnt_q + 2'd1;
            state_q   <= ST_ADDR;
          end
        end
        ST_BLEND: begin
          blend_cnt_q <= blend_cnt_q + 4'd1;
          if (blend_cnt_q == 4'(tsb_pkg::BlendOps)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= (filter_q == tsb_pkg::FilterNearest) ? texel_q[0] : res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wu_q <= tsb_pkg::wrap_coord(in_i.coord_u, wrap_u_q);
      wv_q <= tsb_pkg::wrap_coord(in_i.coord_v, wrap_v_q);
    end
    if (state_q == ST_MY) begin
      x_q <= p;
    end
    if (state_q == ST_PREP) begin
      ax_q <= tsb_pkg::axis_split(x_q, filter_q == tsb_pkg::FilterNearest);
      ay_q <= tsb_pkg::axis_split(p, filter_q == tsb_pkg::FilterNearest);
    end
    if (state_q == ST_LATCH) begin
      texel_q[tex_cnt_q] <= ram_rdata;
    end
    if ((state_q == ST_BLEND) && (blend_cnt_q != 4'd0)) begin
      case (cap_idx[3:2])
        2'd0:    lc_q[{cap_idx[1:0], 3'b000} +: 8]  <= cap_val;
        2'd1:    rc_q[{cap_idx[1:0], 3'b000} +: 8]  <= cap_val;
        default: res_q[{cap_idx[1:0], 3'b000} +: 8] <= cap_val;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red   = out_data_q[7:0];
  assign out_o.green = out_data_q[15:8];
  assign out_o.blue  = out_data_q[23:16];
  assign out_o.alpha = out_data_q[31:24];

  `TSB_ASSERT_NXT(a_sample_starts, clk_i, rst_ni, in_acc && (in_i.command == tsb_pkg::CmdSample), state_q == ST_MX, "sample item did not start the sequencer")
  `TSB_ASSERT_NXT(a_write_no_result, clk_i, rst_ni, in_acc && (in_i.command == tsb_pkg::CmdWrite) && !out_valid_q, !out_valid_q, "write item produced a result")
  `TSB_ASSERT_IMP(a_blend_complete, clk_i, rst_ni, (state_q == ST_DONE) && (filter_q == tsb_pkg::FilterLinear), blend_cnt_q == 4'(tsb_pkg::BlendOps + 1), "bilinear result taken before all blends done")
  `TSB_ASSERT_IMP(a_nearest_one_fetch, clk_i, rst_ni, (state_q == ST_LATCH) && (filter_q == tsb_pkg::FilterNearest), tex_cnt_q == 2'd0, "nearest sample fetched more than one texel")

endmodule

// ===== rtl/core/tsb_ram.sv =====
// Generic single-port RAM with registered read.
module tsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tsb_mac.sv =====
// Shared signed multiply-add unit, result registered.
module tsb_mac (
  input  logic                            clk_i,
  input  tsb_pkg::mac_op_t                op_i,
  output logic signed [tsb_pkg::MacW-1:0] p_o
);

  logic signed [2*tsb_pkg::OpW-1:0] prod;
  logic signed [tsb_pkg::MacW-1:0]  p_d;
  logic signed [tsb_pkg::MacW-1:0]  p_q;

  assign prod = op_i.a * op_i.b;
  assign p_d  = $signed(prod[tsb_pkg::MacW-1:0]) + op_i.c;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== test/texture_sampler_bilinear_tb.sv =====
// Self-checking testbench for the bilinear texture sampler: texel loads, sampling, wrap modes.
`timescale 1ns / 1ps

module texture_sampler_bilinear_tb;

  localparam logic [1:0] WrapFrac    = 2'd2;
  localparam logic [1:0] WrapFracAlt = 2'd3;
  localparam int         IdleLimit   = 3000;
  localparam int         LongHold    = 400;
  localparam int         DrainWait   = 40;
  localparam int         RandomItems = 1250;

  typedef struct {
    logic               command;
    logic [15:0]        index;
    logic [31:0]        color;
    logic signed [23:0] u;
    logic signed [23:0] v;
    int                 gap;
  } req_t;

  typedef struct packed {
    logic [3:0][15:0] addr;
    logic [16:0]      tx;
    logic [16:0]      ty;
  } taps_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tsb_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tsb_pkg::CfgDataW-1:0] cfg_data_i;

  tsb_in_if  in_if ();
  tsb_out_if out_if ();

  texture_sampler_bilinear uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // shadow copy of the block's settings and texel store
  logic                cfg_filter;
  logic [1:0]          cfg_wrap_u;
  logic [1:0]          cfg_wrap_v;
  logic [8:0]          cfg_width;
  logic [8:0]          cfg_height;
  logic [31:0]         texel_mem [0:65535];
  bit                  seen_texel [0:65535];

  req_t                pending_req [$];
  req_t                cur_req;
  logic [31:0]         colour_due [$];
  logic [31:0]         exp_colour;
  bit                  idle_on;
  int                  gap_cnt;
  int                  stall_cnt;
  int                  stall_draw;
  int                  block_cnt;
  int                  hold_req_cnt;
  int                  holds_done;
  int                  idle_cycles;
  int                  mismatch_cnt;
  int                  n_queued;
  int                  n_writes;
  int                  n_nearest;
  int                  n_linear;
  int                  n_results;
  int                  n_settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint wrap_q16(input logic signed [23:0] c, input logic [1:0] mode);
    longint cv;
    longint f;
    longint r;
    cv = c;
    if (cv >= 0 && cv <= 65536) return cv;
    if (cv < 0) f = -((-cv) % 65536);
    else f = cv % 65536;
    r = (f + 65536) % 65536;
    case (mode)
      tsb_pkg::WrapRepeat: return r;
      tsb_pkg::WrapMirror: return 65536 - r;
      default:             return f;
    endcase
  endfunction

  function automatic longint floor_q16(input longint p);
    return p >>> 16;
  endfunction

  function automatic logic [15:0] texel_addr(input longint col, input longint row,
                                             input longint w);
    logic [63:0] a;
    if (col < 0) col = 0;
    if (row < 0) row = 0;
    a = row * w + col;
    return a[15:0];
  endfunction

  // addresses: left-bottom, left-top, right-bottom, right-top
  function automatic taps_t find_taps(input logic signed [23:0] u, input logic signed [23:0] v);
    longint w;
    longint h;
    longint x;
    longint y;
    longint l;
    longint r;
    longint b;
    longint t;
    taps_t  tp;
    w = (cfg_width > tsb_pkg::MaxDim) ? tsb_pkg::MaxDim : cfg_width;
    h = (cfg_height > tsb_pkg::MaxDim) ? tsb_pkg::MaxDim : cfg_height;
    x = wrap_q16(u, cfg_wrap_u) * ((w == 0) ? 0 : w - 1);
    y = wrap_q16(v, cfg_wrap_v) * ((h == 0) ? 0 : h - 1);
    if (cfg_filter == tsb_pkg::FilterNearest) begin
      l = floor_q16(x + 32768);
      b = floor_q16(y + 32768);
      r = l;
      t = b;
    end else begin
      l = floor_q16(x);
      r = -floor_q16(-x);
      b = floor_q16(y);
      t = -floor_q16(-y);
    end
    tp.addr[0] = texel_addr(l, b, w);
    tp.addr[1] = texel_addr(l, t, w);
    tp.addr[2] = texel_addr(r, b, w);
    tp.addr[3] = texel_addr(r, t, w);
    tp.ty = (t == b) ? 17'h10000 : 17'(y - b * 65536);
    tp.tx = (r == l) ? 17'h10000 : 17'(x - l * 65536);
    return tp;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                      input logic [16:0] t);
    logic [31:0] res;
    longint      ca;
    longint      cb;
    longint      tl;
    logic [63:0] s;
    tl = t;
    for (int k = 0; k < 4; k++) begin
      ca = a[8*k +: 8];
      cb = b[8*k +: 8];
      s = (ca * (65536 - tl) + cb * tl) >> 16;
      res[8*k +: 8] = s[7:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sampled_colour(input logic signed [23:0] u,
                                                 input logic signed [23:0] v);
    taps_t tp;
    tp = find_taps(u, v);
    if (cfg_filter == tsb_pkg::FilterNearest) return texel_mem[tp.addr[0]];
    return mix(mix(texel_mem[tp.addr[0]], texel_mem[tp.addr[1]], tp.ty),
               mix(texel_mem[tp.addr[2]], texel_mem[tp.addr[3]], tp.ty), tp.tx);
  endfunction

  function automatic void push_req(input req_t r);
    r.gap = idle_on ? $urandom_range(0, 11) : 0;
    pending_req.push_back(r);
    n_queued++;
  endfunction

  function automatic void queue_write(input logic [15:0] idx, input logic [31:0] col);
    req_t r;
    seen_texel[idx] = 1'b1;
    r.command = tsb_pkg::CmdWrite;
    r.index   = idx;
    r.color   = col;
    r.u       = 24'($urandom);
    r.v       = 24'($urandom);
    push_req(r);
  endfunction

  // loads any texel the sample would touch before it is first written
  function automatic void queue_sample(input logic signed [23:0] u,
                                       input logic signed [23:0] v);
    req_t  r;
    taps_t tp;
    tp = find_taps(u, v);
    for (int k = 0; k < 4; k++) begin
      if (!seen_texel[tp.addr[k]]) queue_write(tp.addr[k], $urandom);
    end
    r.command = tsb_pkg::CmdSample;
    r.index   = 16'($urandom);
    r.color   = $urandom;
    r.u       = u;
    r.v       = v;
    push_req(r);
  endfunction

  function automatic logic signed [23:0] rand_coord();
    int c;
    case ($urandom_range(0, 7))
      0:       c = $urandom;
      1, 2, 6: c = $urandom_range(0, 65536);
      3:       c = int'($urandom_range(0, 393216)) - 196608;
      4:       c = (int'($urandom_range(0, 6)) - 3) * 65536;
      5: begin
        case ($urandom_range(0, 5))
          0:       c = 0;
          1:       c = 65536;
          2:       c = -65536;
          3:       c = 32768;
          4:       c = 8388607;
          default: c = -8388608;
        endcase
      end
      default: c = 65536 + int'($urandom_range(0, 512)) - 256;
    endcase
    return c[23:0];
  endfunction

  function automatic logic [8:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return 9'd256;
      1:       return 9'd0;
      2:       return 9'($urandom_range(257, 511));
      3:       return 9'd1;
      4:       return 9'($urandom_range(9, 255));
      default: return 9'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic set_reg(input logic [tsb_pkg::CfgIdxW-1:0] idx,
                         input logic [tsb_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      tsb_pkg::RegFilter: cfg_filter = val[0];
      tsb_pkg::RegWrapU:  cfg_wrap_u = val[1:0];
      tsb_pkg::RegWrapV:  cfg_wrap_v = val[1:0];
      tsb_pkg::RegWidth:  cfg_width  = val[8:0];
      tsb_pkg::RegHeight: cfg_height = val[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic f, input logic [1:0] wu, input logic [1:0] wv,
                                input logic [8:0] w, input logic [8:0] h);
    set_reg(tsb_pkg::RegFilter, tsb_pkg::CfgDataW'(f));
    set_reg(tsb_pkg::RegWrapU, tsb_pkg::CfgDataW'(wu));
    set_reg(tsb_pkg::RegWrapV, tsb_pkg::CfgDataW'(wv));
    set_reg(tsb_pkg::RegWidth, w);
    set_reg(tsb_pkg::RegHeight, h);
    n_settings++;
  endtask

  task automatic drain_all();
    while (pending_req.size() != 0 || in_if.valid || colour_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // request driver; the model is updated as each item is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.command     <= tsb_pkg::CmdWrite;
      in_if.texel_index <= '0;
      in_if.texel_color <= '0;
      in_if.coord_u     <= '0;
      in_if.coord_v     <= '0;
      gap_cnt           <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (cur_req.command == tsb_pkg::CmdWrite) begin
          texel_mem[cur_req.index] = cur_req.color;
          n_writes++;
        end else begin
          colour_due.push_back(sampled_colour(cur_req.u, cur_req.v));
          if (cfg_filter == tsb_pkg::FilterNearest) n_nearest++;
          else n_linear++;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_req.size() != 0 && gap_cnt >= pending_req[0].gap) begin
          cur_req = pending_req.pop_front();
          in_if.valid       <= 1'b1;
          in_if.command     <= cur_req.command;
          in_if.texel_index <= cur_req.index;
          in_if.texel_color <= cur_req.color;
          in_if.coord_u     <= cur_req.u;
          in_if.coord_v     <= cur_req.v;
          gap_cnt           <= 0;
        end else begin
          in_if.valid <= 1'b0;
          if (pending_req.size() != 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // result checker and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= 0;
      block_cnt    <= 0;
      holds_done   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (colour_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected item r=%02h g=%02h b=%02h a=%02h", $realtime,
                     out_if.red, out_if.green, out_if.blue, out_if.alpha);
        end else begin
          exp_colour = colour_due.pop_front();
          if (out_if.red !== exp_colour[7:0] || out_if.green !== exp_colour[15:8] ||
              out_if.blue !== exp_colour[23:16] || out_if.alpha !== exp_colour[31:24]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: mismatch exp r=%02h g=%02h b=%02h a=%02h",
                        " got r=%02h g=%02h b=%02h a=%02h"},
                       $realtime, exp_colour[7:0], exp_colour[15:8], exp_colour[23:16],
                       exp_colour[31:24], out_if.red, out_if.green, out_if.blue,
                       out_if.alpha);
          end
        end
      end
      if (holds_done != hold_req_cnt) begin
        holds_done   <= hold_req_cnt;
        block_cnt    <= LongHold;
        out_if.ready <= 1'b0;
      end else if (block_cnt > 0) begin
        block_cnt    <= block_cnt - 1;
        out_if.ready <= (block_cnt == 1);
      end else if (out_if.valid && out_if.ready) begin
        stall_draw   = idle_on ? $urandom_range(0, 11) : 0;
        stall_cnt    <= stall_draw;
        out_if.ready <= (stall_draw == 0);
      end else if (stall_cnt > 0) begin
        stall_cnt    <= stall_cnt - 1;
        out_if.ready <= (stall_cnt == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int rand_start;
    int phase_no;
    int count;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = tsb_pkg::RegFilter;
    cfg_data_i        = '0;
    cfg_filter        = tsb_pkg::FilterNearest;
    cfg_wrap_u        = tsb_pkg::WrapRepeat;
    cfg_wrap_v        = tsb_pkg::WrapRepeat;
    cfg_width         = 9'd1;
    cfg_height        = 9'd1;
    idle_on           = 1'b1;
    hold_req_cnt      = 0;
    n_queued          = 0;
    n_settings        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nearest, repeat: colour extremes, top index, half-up rounding, coordinate extremes
    apply_settings(tsb_pkg::FilterNearest, tsb_pkg::WrapRepeat, tsb_pkg::WrapRepeat,
                   9'd2, 9'd2);
    queue_write(16'd0, 32'h0000_0000);
    queue_write(16'd1, 32'hFFFF_FFFF);
    queue_write(16'd2, 32'h00FF_00FF);
    queue_write(16'd3, 32'hFF00_FF00);
    queue_write(16'hFFFF, 32'h1234_5678);
    queue_sample(24'sd0, 24'sd0);
    queue_sample(24'sd65536, 24'sd65536);
    queue_sample(24'sd32768, 24'sd32767);
    queue_sample(-24'sd81920, -24'sd16384);
    queue_sample(24'sh7FFFFF, 24'sh800000);
    drain_all();

    // bilinear, mirror on u, fraction only on v: negative row clamp, equal neighbours
    apply_settings(tsb_pkg::FilterLinear, tsb_pkg::WrapMirror, WrapFrac, 9'd2, 9'd2);
    queue_sample(24'sd32768, 24'sd32768);
    queue_sample(-24'sd16384, -24'sd16384);
    queue_sample(24'sd98304, 24'sd98304);
    queue_sample(24'sd65536, 24'sd0);
    queue_sample(24'sh7FFFFF, 24'sh800000);
    drain_all();

    // full size, last texel of the store
    apply_settings(tsb_pkg::FilterLinear, WrapFracAlt, WrapFracAlt, 9'd256, 9'd256);
    queue_sample(24'sd65536, 24'sd65536);
    queue_sample(24'sd0, 24'sd0);
    drain_all();

    // oversized width saturates, zero height pins the row
    apply_settings(tsb_pkg::FilterNearest, tsb_pkg::WrapRepeat, tsb_pkg::WrapMirror,
                   9'd511, 9'd0);
    queue_sample(24'sd12345, 24'sd54321);
    drain_all();

    rand_start = n_queued;
    phase_no   = 0;
    while (n_queued - rand_start < RandomItems) begin
      idle_on = (phase_no % 4 != 2) && (phase_no != 1);
      apply_settings(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), rand_dim(), rand_dim());
      count = $urandom_range(30, 90);
      repeat (count) begin
        if ($urandom_range(0, 9) < 2) queue_write(16'($urandom), $urandom);
        else queue_sample(rand_coord(), rand_coord());
      end
      // receiver holds off while the sender streams with no gaps
      if (phase_no == 1) hold_req_cnt++;
      drain_all();
      phase_no++;
    end

    $display("Covered %0d texel writes, %0d nearest and %0d bilinear samples, %0d results",
             n_writes, n_nearest, n_linear, n_results);
    $display("across %0d register settings, with one long receiver hold-off", n_settings);
    if (mismatch_cnt == 0 && colour_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_cnt, colour_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
